// ===== rtl/u2u8ln_pkg.sv =====
// shared types and constants for the utf-16 to utf-8 long name transcoder
// no dependencies; imported by every module of the block
package u2u8ln_pkg;

  // byte counter width of the name output
  localparam int COUNT_WIDTH = 10;
  localparam int CAP_W       = 10;
  localparam int UNIT_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int CP_W        = 21;
  localparam int MAX_ENC     = 4;
  localparam int ENC_IDX_W   = $clog2(MAX_ENC);
  localparam int NBYTES_W    = 3;
  // compare width wide enough for counter, capacity and one more character
  localparam int CMP_W       = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 1;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((1 << COUNT_WIDTH) - 1);

  // entry queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // surrogate classes, by the top six bits of a unit
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;
  localparam logic [CP_W-1:0] SUPP_BASE = CP_W'(32'h10000);

  // all bytes caused by one input unit
  typedef struct packed {
    logic [MAX_ENC-1:0][BYTE_W-1:0] data;  // encoded bytes, first in [0]
    logic [NBYTES_W-1:0]            nbytes; // 0 to 4 encoded bytes
    logic                           term;   // nul follows the encoded bytes
  } entry_t;

endpackage

// ===== rtl/u2u8ln_front.sv =====
// front part: accepts code units, tracks name state, encodes to utf-8
// depends on u2u8ln_pkg; pushes one entry per unit that gives bytes
module u2u8ln_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [u2u8ln_pkg::CAP_W-1:0]  out_capacity,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [u2u8ln_pkg::UNIT_W-1:0] code_unit,
  input  logic                        last_unit,
  input  logic                        q_full,
  output logic                        push,
  output u2u8ln_pkg::entry_t          push_entry
);
  import u2u8ln_pkg::*;

  logic [9:0]             pending_high, pending_high_next;
  logic                   have_pending, have_pending_next;
  logic [COUNT_WIDTH-1:0] bytes_written, bytes_written_next;
  logic                   skipping, skipping_next;

  logic                   in_acc;
  logic [CMP_W-1:0]       cap_ext, bound, bw_ext, bw_sum, bw_after;
  logic                   is_hi, is_lo, full, emit, fits, emit_ok, end_name;
  logic [CP_W-1:0]        cp;
  logic [NBYTES_W-1:0]    len;
  logic [MAX_ENC-1:0][BYTE_W-1:0] enc;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;

  assign cap_ext = CMP_W'(out_capacity);
  assign bound   = (cap_ext < COUNT_MAX) ? cap_ext : COUNT_MAX;
  assign bw_ext  = CMP_W'(bytes_written);
  assign full    = bw_ext >= bound;

  assign is_hi = code_unit[15:10] == HI_SURR_TAG;
  assign is_lo = code_unit[15:10] == LO_SURR_TAG;

  // classify the unit
  always_comb begin
    emit = 1'b0;
    cp   = CP_W'(code_unit);
    if (have_pending) begin
      emit = is_lo;
      cp   = CP_W'({pending_high, code_unit[9:0]}) + SUPP_BASE;
    end else if (!is_hi && !is_lo) begin
      emit = 1'b1;
    end
  end

  // utf-8 encoding
  always_comb begin
    enc = '0;
    if (cp < CP_W'(32'h80)) begin
      len    = NBYTES_W'(1);
      enc[0] = cp[7:0];
    end else if (cp < CP_W'(32'h800)) begin
      len    = NBYTES_W'(2);
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      len    = NBYTES_W'(3);
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
    end else begin
      len    = NBYTES_W'(4);
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
    end
  end

  assign bw_sum   = bw_ext + CMP_W'(len);
  assign fits     = bw_sum <= bound;
  // full output or zero unit ends the name without decoding
  assign emit_ok  = !full && (code_unit != '0) && emit && fits;
  assign bw_after = emit_ok ? bw_sum : bw_ext;
  assign end_name = full || (code_unit == '0) || last_unit || (bw_after >= bound);

  assign push              = in_acc && !skipping && (emit_ok || end_name);
  assign push_entry.data   = enc;
  assign push_entry.nbytes = emit_ok ? len : '0;
  assign push_entry.term   = end_name;

  always_comb begin
    pending_high_next  = pending_high;
    have_pending_next  = have_pending;
    bytes_written_next = bytes_written;
    skipping_next      = skipping;
    if (in_acc) begin
      if (skipping) begin
        if (last_unit) begin
          skipping_next = 1'b0;
          bytes_written_next = '0;
          have_pending_next = 1'b0;
          pending_high_next = '0;
        end
      end else begin
        if (!full && (code_unit != '0)) begin
          if (have_pending) begin
            have_pending_next = 1'b0;
          end else if (is_hi) begin
            have_pending_next = 1'b1;
            pending_high_next = code_unit[9:0];
          end
        end
        bytes_written_next = COUNT_WIDTH'(bw_after);
        if (end_name) begin
          have_pending_next = 1'b0;
          pending_high_next = '0;
          if (last_unit) begin
            bytes_written_next = '0;
            skipping_next = 1'b0;
          end else begin
            skipping_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high  <= '0;
      have_pending  <= 1'b0;
      bytes_written <= '0;
      skipping      <= 1'b0;
    end else begin
      pending_high  <= pending_high_next;
      have_pending  <= have_pending_next;
      bytes_written <= bytes_written_next;
      skipping      <= skipping_next;
    end
  end

endmodule

// ===== rtl/u2u8ln_queue.sv =====
// small register queue of encoded entries between front and back
// depends on u2u8ln_pkg
module u2u8ln_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u2u8ln_pkg::entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               nonempty,
  output u2u8ln_pkg::entry_t head
);
  import u2u8ln_pkg::*;

  entry_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign full     = count == (Q_PTR_W+1)'(Q_DEPTH);
  assign nonempty = count != '0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/u2u8ln_back.sv =====
// back part: walks the head entry one byte per beat into the output register
// depends on u2u8ln_pkg
module u2u8ln_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_nonempty,
  input  u2u8ln_pkg::entry_t           head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [u2u8ln_pkg::BYTE_W-1:0] out_byte,
  output logic                         end_of_name,
  output logic                         last_of_run
);
  import u2u8ln_pkg::*;

  logic [NBYTES_W-1:0] idx;
  logic                advance, load, is_data, is_last;

  assign advance = !out_valid || !out_stall;
  assign load    = advance && q_nonempty;
  assign is_data = idx < head.nbytes;
  assign is_last = (idx + 1'b1) == (head.nbytes + NBYTES_W'(head.term));
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      out_valid <= q_nonempty;
      if (load) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= is_data ? head.data[idx[ENC_IDX_W-1:0]] : '0;
      end_of_name <= !is_data;
      last_of_run <= is_last;
    end
  end

endmodule

// ===== rtl/utf16_to_utf8_long_name.sv =====
// top level of the utf-16 to utf-8 long name transcoder
// depends on u2u8ln_pkg, u2u8ln_front, u2u8ln_queue, u2u8ln_back
//
// usage:
//   input channel: code_unit and last_unit, one utf-16 unit per beat, taken
//   when in_valid is high and in_stall is low. in_stall rises only while the
//   entry queue is full.
//   output channel: out_byte with end_of_name and last_of_run, one byte per
//   beat, taken when out_valid is high and out_stall is low. last_of_run
//   marks the final byte caused by one input unit; end_of_name marks the nul
//   that closes a name.
//   config: cfg_wr_en writes cfg_wr_data into out_capacity (reset 511), the
//   byte limit of a name before its nul. write only while the block is idle.
// timing:
//   the front decodes a unit in the cycle it is taken and pushes its entry;
//   the back loads its bytes from the queue into the output register and
//   drains one byte per cycle while out_stall is low, so units giving one
//   byte (ascii) stream at one unit per cycle; a multi-byte unit holds the
//   output byte by byte, and the four-entry queue absorbs short bursts of them.
// reset clears name state, queue and output valid. a stalled output holds
// its byte; the front keeps taking units until the queue fills.
module utf16_to_utf8_long_name (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [u2u8ln_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [u2u8ln_pkg::UNIT_W-1:0] code_unit,
  input  logic                          last_unit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u2u8ln_pkg::BYTE_W-1:0] out_byte,
  output logic                          end_of_name,
  output logic                          last_of_run
);
  import u2u8ln_pkg::*;

  // capacity register, the single config register
  logic [CAP_W-1:0] out_capacity;

  // front to queue
  logic   push;
  entry_t push_entry;
  // queue to back
  logic   q_full, q_nonempty, pop;
  entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_W'(511);
    end else if (cfg_wr_en) begin
      out_capacity <= cfg_wr_data;
    end
  end

  // classify and encode each unit, track surrogate and byte count
  u2u8ln_front u_front (
    .clk          (clk),
    .rst          (rst),
    .out_capacity (out_capacity),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .code_unit    (code_unit),
    .last_unit    (last_unit),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // decouples unit intake from byte drain
  u2u8ln_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .head       (head)
  );

  // serializes each entry onto the output register
  u2u8ln_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_nonempty  (q_nonempty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .end_of_name (end_of_name),
    .last_of_run (last_of_run)
  );

endmodule
